@@ src/edpr_pkg.sv @@
// Shared types and constants for the peak/RMS envelope follower.
// No dependencies; every other file in src except edpr_chk uses this package by scoped name.
`default_nettype none

package edpr_pkg;

    localparam int SIG_FRAC_BITS   = 27;
    localparam int COEFF_FRAC_BITS = 31;
    localparam int QUEUE_DEPTH     = 2;

    localparam int SAMPLE_W = 32;
    localparam int LEVEL_W  = 31;
    localparam int COEFF_W  = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // Rounding offsets for the two fixed-point shifts.
    localparam logic [63:0]        SIG_RND   = 64'd1 << (SIG_FRAC_BITS - 1);
    localparam logic signed [63:0] COEFF_RND = 64'sd1 <<< (COEFF_FRAC_BITS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

    typedef enum logic {
        MODE_PEAK   = 1'b0,
        MODE_SQUARE = 1'b1
    } detect_mode_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_SQR,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_MUL,
        BE_UPD
    } be_state_t;

    // Detection value handed from the front end to the queue.
    typedef struct packed {
        logic               push;
        logic [LEVEL_W-1:0] det;
    } edpr_item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } edpr_qstat_t;

endpackage

`default_nettype wire

@@ src/edpr_front.sv @@
// Front end: accepts samples and reduces each to a 31-bit detection value.
// Depends on edpr_pkg; feeds edpr_queue.
`default_nettype none

module edpr_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [edpr_pkg::SAMPLE_W-1:0] sample,
    input  wire edpr_pkg::detect_mode_t            mode,
    input  wire edpr_pkg::edpr_qstat_t             qstat,
    output edpr_pkg::edpr_item_t                   item
);

    edpr_pkg::fe_state_t    state_reg, state_next;
    edpr_pkg::detect_mode_t mode_reg, mode_next;
    logic [31:0]            mag_reg, mag_next;
    logic [63:0]            sq_reg, sq_next;
    logic [63:0]            sq_rnd;
    logic [63:0]            sq_shift;
    logic [edpr_pkg::LEVEL_W-1:0] det_peak, det_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edpr_pkg::FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        mag_reg  <= mag_next;
        sq_reg   <= sq_next;
    end

    // Peak: magnitude, with the most negative sample clipped to full scale.
    assign det_peak = mag_reg[31] ? edpr_pkg::LEVEL_MAX : mag_reg[30:0];

    assign sq_rnd   = sq_reg + edpr_pkg::SIG_RND;
    assign sq_shift = sq_rnd >> edpr_pkg::SIG_FRAC_BITS;
    assign det_sq   = (sq_shift[63:31] != '0) ? edpr_pkg::LEVEL_MAX : sq_shift[30:0];

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        mag_next   = mag_reg;
        sq_next    = sq_reg;
        in_ready   = 1'b0;
        item.push  = 1'b0;
        item.det   = (mode_reg == edpr_pkg::MODE_SQUARE) ? det_sq : det_peak;
        unique case (state_reg)
            edpr_pkg::FE_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = mode;
                    mag_next   = sample[31] ? (32'(~sample) + 32'd1) : 32'(sample);
                    state_next = edpr_pkg::FE_SQR;
                end
            end
            edpr_pkg::FE_SQR:
            begin
                sq_next    = 64'(mag_reg) * 64'(mag_reg);
                state_next = edpr_pkg::FE_PUSH;
            end
            edpr_pkg::FE_PUSH:
            begin
                // hold until the queue has room
                if (!qstat.full)
                begin
                    item.push  = 1'b1;
                    state_next = edpr_pkg::FE_IDLE;
                end
            end
            default:
            begin
                state_next = edpr_pkg::FE_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/edpr_queue.sv @@
// Short FIFO of detection values between the front end and the back end.
// Depends on edpr_pkg.
`default_nettype none

module edpr_queue #(
    parameter int DEPTH = edpr_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire edpr_pkg::edpr_item_t          item,
    input  wire logic                          pop,
    output logic [edpr_pkg::LEVEL_W-1:0]       head,
    output edpr_pkg::edpr_qstat_t              qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic [edpr_pkg::LEVEL_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign qstat.full  = (count_reg == FULL);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = item.push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item.det;
        end
    end

endmodule

`default_nettype wire

@@ src/edpr_back.sv @@
// Back end: envelope recurrence (select coefficient, multiply, round, saturate)
// and the output register. Depends on edpr_pkg; reads from edpr_queue.
`default_nettype none

module edpr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [edpr_pkg::COEFF_W-1:0]  attack_coeff,
    input  wire logic [edpr_pkg::COEFF_W-1:0]  release_coeff,
    input  wire edpr_pkg::edpr_qstat_t         qstat,
    input  wire logic [edpr_pkg::LEVEL_W-1:0]  head,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [edpr_pkg::LEVEL_W-1:0]       envelope_out
);

    edpr_pkg::be_state_t state_reg, state_next;
    logic [edpr_pkg::LEVEL_W-1:0] env_reg, env_next;
    logic                         ovalid_reg, ovalid_next;
    logic [edpr_pkg::LEVEL_W-1:0] oenv_reg, oenv_next;
    logic [edpr_pkg::COEFF_W-1:0] coeff_reg, coeff_next;
    logic signed [31:0]           diff_reg, diff_next;
    logic signed [63:0]           prod_reg, prod_next;
    logic signed [63:0]           step;
    logic signed [63:0]           level;
    logic [edpr_pkg::LEVEL_W-1:0] level_sat;

    // Arithmetic shift floors; with the offset added it rounds to nearest, ties toward plus infinity.
    assign step  = (prod_reg + edpr_pkg::COEFF_RND) >>> edpr_pkg::COEFF_FRAC_BITS;
    assign level = step + $signed({33'd0, env_reg});

    always_comb
    begin
        priority if (level[63])
        begin
            level_sat = '0;
        end
        else if (level[62:31] != '0)
        begin
            level_sat = edpr_pkg::LEVEL_MAX;
        end
        else
        begin
            level_sat = level[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= edpr_pkg::BE_IDLE;
            env_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            env_reg    <= env_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oenv_reg  <= oenv_next;
        coeff_reg <= coeff_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
    end

    assign out_valid    = ovalid_reg;
    assign envelope_out = oenv_reg;

    always_comb
    begin
        state_next  = state_reg;
        env_next    = env_reg;
        oenv_next   = oenv_reg;
        coeff_next  = coeff_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        pop         = 1'b0;
        ovalid_next = ovalid_reg && !out_ready;
        unique case (state_reg)
            edpr_pkg::BE_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    coeff_next = (head > env_reg) ? attack_coeff : release_coeff;
                    diff_next  = $signed({1'b0, head}) - $signed({1'b0, env_reg});
                    state_next = edpr_pkg::BE_MUL;
                end
            end
            edpr_pkg::BE_MUL:
            begin
                prod_next  = 64'($signed({1'b0, coeff_reg})) * 64'(diff_reg);
                state_next = edpr_pkg::BE_UPD;
            end
            edpr_pkg::BE_UPD:
            begin
                // hold the update until the output register frees up
                if (!ovalid_reg || out_ready)
                begin
                    env_next    = level_sat;
                    oenv_next   = level_sat;
                    ovalid_next = 1'b1;
                    state_next  = edpr_pkg::BE_IDLE;
                end
            end
            default:
            begin
                state_next = edpr_pkg::BE_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/envelope_detector_peak_rms_core.sv @@
// Top level of the attack/release envelope follower: configuration registers,
// front end, detection queue and back end. Depends on edpr_pkg and submodules.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, sample[31:0]          | in
//  output  | out_valid, out_ready, envelope_out[30:0]  | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// The front end finishes each sample (accept, square, push) before it takes another;
// the back end retires each item in three steps (pop and compare, multiply, update).
// An unstalled item passes the square, push, pop, multiply and update steps before
// out_valid rises. The three steps on each side set the rate.
// Reset clears the envelope to zero and loads the coefficient defaults.
// A stalled output holds the back end in its update step; the queue then fills
// and stops the front end. Configuration writes are always taken.
`default_nettype none

module envelope_detector_peak_rms_core #(
    parameter int QUEUE_DEPTH = edpr_pkg::QUEUE_DEPTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [edpr_pkg::SAMPLE_W-1:0]  sample,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [edpr_pkg::LEVEL_W-1:0]               envelope_out,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [edpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [edpr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [edpr_pkg::COEFF_W-1:0] attack_reg, release_reg;
    edpr_pkg::detect_mode_t       mode_reg;
    edpr_pkg::edpr_item_t         item;
    edpr_pkg::edpr_qstat_t        qstat;
    logic [edpr_pkg::LEVEL_W-1:0] head;
    logic                         pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= edpr_pkg::COEFF_W'(16777216);
            release_reg <= edpr_pkg::COEFF_W'(1048576);
            mode_reg    <= edpr_pkg::MODE_PEAK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes beyond the register list
            unique case (cfg_index)
                edpr_pkg::CFG_ATTACK:  attack_reg  <= cfg_data[edpr_pkg::COEFF_W-1:0];
                edpr_pkg::CFG_RELEASE: release_reg <= cfg_data[edpr_pkg::COEFF_W-1:0];
                edpr_pkg::CFG_MODE:    mode_reg    <= edpr_pkg::detect_mode_t'(cfg_data[0]);
                default:               ;
            endcase
        end
    end

    edpr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .mode     (mode_reg),
        .qstat    (qstat),
        .item     (item)
    );

    edpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    edpr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .qstat         (qstat),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .envelope_out  (envelope_out)
    );

endmodule

`default_nettype wire

@@ src/edpr_chk.sv @@
// Port-level checker for the envelope follower, bound to the top level.
// Depends on envelope_detector_peak_rms_core's port list only.
`default_nettype none

module edpr_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [30:0] envelope_out,
    input wire logic        cfg_ready
);

    logic [3:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 4'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_next = pend_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A result never appears without an accepted item behind it.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 4'd0))
        else $error("result shown with no pending item");

    // The front end squares each sample before it can take another.
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(envelope_out))
        else $error("stalled result dropped or changed");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port closed");

endmodule

bind envelope_detector_peak_rms_core edpr_chk u_edpr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .envelope_out (envelope_out),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
